>>> design/spiee_pkg.sv
// Shared types, codes and helpers for the SPI EEPROM command sequencer.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package spiee_pkg;

	// Defaults for top-level parameters
	localparam int ADDR_WIDTH_DEF = 16;
	localparam int Q_DEPTH        = 2;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LOG2 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTOSLEEP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT     = 2'd3;

	localparam logic [3:0] RST_PAGE_LOG2 = 4'd6;
	localparam logic [7:0] RST_RETRY     = 8'd10;
	localparam logic       RST_AUTOSLEEP = 1'b0;
	localparam logic       RST_SPLIT     = 1'b1;

	// Input item kinds
	localparam logic [1:0] KIND_REQ    = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;
	localparam logic [1:0] KIND_DATA   = 2'd3;

	// Request ops
	localparam logic [2:0] OP_WRITE = 3'd0;
	localparam logic [2:0] OP_READ  = 3'd1;
	localparam logic [2:0] OP_ERASE = 3'd2;
	localparam logic [2:0] OP_SLEEP = 3'd3;
	localparam logic [2:0] OP_WAKE  = 3'd4;

	// Outcome codes
	localparam logic [1:0] OUT_RUN     = 2'd0;
	localparam logic [1:0] OUT_DONE    = 2'd1;
	localparam logic [1:0] OUT_TIMEOUT = 2'd2;
	localparam logic [1:0] OUT_REJECT  = 2'd3;

	// 25-series instruction bytes
	localparam logic [7:0] CMD_WREN  = 8'h06;
	localparam logic [7:0] CMD_RDSR  = 8'h05;
	localparam logic [7:0] CMD_READ  = 8'h03;
	localparam logic [7:0] CMD_WRITE = 8'h02;
	localparam logic [7:0] CMD_ERASE = 8'hC7;
	localparam logic [7:0] CMD_SLEEP = 8'hB9;
	localparam logic [7:0] CMD_WAKE  = 8'hAB;

	// Status register: WIP/WEL pair must read as "enabled, not busy"
	localparam logic [1:0] STATUS_READY = 2'b10;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  op;
		logic [15:0] address;
		logic [15:0] length;
		logic [7:0]  value;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_start;
		logic       frame_end;
		logic       capture;
		logic       start_wait;
		logic [1:0] outcome;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [3:0] page_size_log2;
		logic [7:0] retry_limit;
		logic       auto_sleep;
		logic       page_split;
	} cfg_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_STATUS,
		PH_TICK,
		PH_WDATA,
		PH_RDATA
	} phase_t;

	// What follows the optional head byte of a descriptor
	typedef enum logic [2:0] {
		TAIL_NONE,
		TAIL_DONE,
		TAIL_TIMEOUT,
		TAIL_REJECT,
		TAIL_WAIT,
		TAIL_POLL,
		TAIL_ADDR
	} tail_t;

	typedef struct packed {
		logic       en;
		logic [7:0] data;
		logic       fs;
		logic       fe;
		logic       cap;
	} head_t;

	// One queue entry: all the beats that one accepted item produces
	typedef struct packed {
		head_t       head;
		tail_t       tail;
		logic [15:0] addr;
	} desc_t;

	// Last address of the frame that starts at cs; span is final_a - cs
	function automatic logic [15:0] chunk_end(input logic [15:0] cs,
			input logic [15:0] final_a, input logic [15:0] span,
			input logic [3:0] psl2, input logic split);
		logic [16:0] one_hot;
		logic [15:0] mask;
		logic [15:0] page_end;
		logic [15:0] room;
		one_hot  = 17'd1 << psl2;
		mask     = 16'(one_hot - 17'd1);
		page_end = cs | mask;
		room     = page_end - cs;
		return (!split || span <= room) ? final_a : page_end;
	endfunction

endpackage

`default_nettype wire

>>> design/spiee_front.sv
// Front end: config registers, command state and classification of each item
// into one beat descriptor. Depends on spiee_pkg.
`default_nettype none

module spiee_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  spiee_pkg::item_t       item,
	input  wire logic              q_full,
	input  wire logic              cfg_valid,
	input  spiee_pkg::cfg_wr_t     cfg_wr,
	output logic                   q_wr,
	output spiee_pkg::desc_t       q_desc
);

	spiee_pkg::cfg_t   cfg_q;
	spiee_pkg::phase_t phase_q, phase_d;
	logic [2:0]        op_q, op_d;
	logic [15:0]       cs_q, cs_d;
	logic [15:0]       fin_q, fin_d;
	logic [15:0]       last_q, last_d;
	logic [7:0]        polls_q, polls_d;

	logic [15:0] req_final;
	logic [15:0] req_dist;
	logic [15:0] nxt_cs;
	logic [15:0] nxt_dist;
	logic [7:0]  polls_inc;
	logic        at_end;
	logic        accept;

	assign accept    = push && !q_full;
	assign q_wr      = accept;
	assign req_dist  = item.length - 16'd1;
	assign req_final = item.address + req_dist;
	assign nxt_cs    = last_q + 16'd1;
	assign nxt_dist  = fin_q - nxt_cs;
	assign polls_inc = polls_q + 8'd1;
	assign at_end    = (cs_q == last_q);

	always_comb begin
		phase_d = phase_q;
		op_d    = op_q;
		cs_d    = cs_q;
		fin_d   = fin_q;
		last_d  = last_q;
		polls_d = polls_q;
		q_desc      = '0;
		q_desc.tail = spiee_pkg::TAIL_REJECT;
		q_desc.addr = cs_q;
		priority if (item.kind == spiee_pkg::KIND_REQ && phase_q == spiee_pkg::PH_IDLE
				&& item.op <= spiee_pkg::OP_WAKE) begin
			if (item.op == spiee_pkg::OP_WAKE) begin
				q_desc.head = '{en: 1'b1, data: spiee_pkg::CMD_WAKE, fs: 1'b1, fe: 1'b1,
					cap: 1'b0};
				q_desc.tail = spiee_pkg::TAIL_DONE;
			end else if (item.op <= spiee_pkg::OP_READ && item.length == 16'd0) begin
				q_desc.tail = spiee_pkg::TAIL_DONE;
			end else begin
				op_d    = item.op;
				polls_d = '0;
				if (item.op <= spiee_pkg::OP_READ) begin
					cs_d   = item.address;
					fin_d  = req_final;
					last_d = (item.op == spiee_pkg::OP_WRITE)
						? spiee_pkg::chunk_end(item.address, req_final, req_dist,
							cfg_q.page_size_log2, cfg_q.page_split)
						: req_final;
				end
				if (cfg_q.auto_sleep && item.op <= spiee_pkg::OP_ERASE) begin
					q_desc.head = '{en: 1'b1, data: spiee_pkg::CMD_WAKE, fs: 1'b1, fe: 1'b1,
						cap: 1'b0};
				end
				q_desc.tail = spiee_pkg::TAIL_POLL;
				phase_d     = spiee_pkg::PH_STATUS;
			end
		end else if (item.kind == spiee_pkg::KIND_STATUS && phase_q == spiee_pkg::PH_STATUS)
				begin
			polls_d = polls_inc;
			if (item.value[1:0] == spiee_pkg::STATUS_READY) begin
				priority if (op_q == spiee_pkg::OP_WRITE) begin
					q_desc.head = '{en: 1'b1, data: spiee_pkg::CMD_WRITE, fs: 1'b1, fe: 1'b0,
						cap: 1'b0};
					q_desc.tail = spiee_pkg::TAIL_ADDR;
					phase_d     = spiee_pkg::PH_WDATA;
				end else if (op_q == spiee_pkg::OP_READ) begin
					q_desc.head = '{en: 1'b1, data: spiee_pkg::CMD_READ, fs: 1'b1, fe: 1'b0,
						cap: 1'b0};
					q_desc.tail = spiee_pkg::TAIL_ADDR;
					phase_d     = spiee_pkg::PH_RDATA;
				end else if (op_q == spiee_pkg::OP_ERASE) begin
					q_desc.head = '{en: 1'b1, data: spiee_pkg::CMD_ERASE, fs: 1'b1, fe: 1'b1,
						cap: 1'b0};
					if (cfg_q.auto_sleep) begin
						op_d        = spiee_pkg::OP_SLEEP;
						polls_d     = '0;
						q_desc.tail = spiee_pkg::TAIL_POLL;
					end else begin
						q_desc.tail = spiee_pkg::TAIL_DONE;
						phase_d     = spiee_pkg::PH_IDLE;
					end
				end else begin
					q_desc.head = '{en: 1'b1, data: spiee_pkg::CMD_SLEEP, fs: 1'b1, fe: 1'b1,
						cap: 1'b0};
					q_desc.tail = spiee_pkg::TAIL_DONE;
					phase_d     = spiee_pkg::PH_IDLE;
				end
			end else if (polls_inc >= cfg_q.retry_limit) begin
				q_desc.tail = spiee_pkg::TAIL_TIMEOUT;
				phase_d     = spiee_pkg::PH_IDLE;
			end else begin
				q_desc.tail = spiee_pkg::TAIL_WAIT;
				phase_d     = spiee_pkg::PH_TICK;
			end
		end else if (item.kind == spiee_pkg::KIND_TICK && phase_q == spiee_pkg::PH_TICK) begin
			q_desc.tail = spiee_pkg::TAIL_POLL;
			phase_d     = spiee_pkg::PH_STATUS;
		end else if (item.kind == spiee_pkg::KIND_DATA && (phase_q == spiee_pkg::PH_WDATA
				|| phase_q == spiee_pkg::PH_RDATA)) begin
			q_desc.head.en   = 1'b1;
			q_desc.head.data = (phase_q == spiee_pkg::PH_WDATA) ? item.value : 8'h00;
			q_desc.head.fe   = at_end;
			q_desc.head.cap  = (phase_q == spiee_pkg::PH_RDATA);
			if (!at_end) begin
				cs_d        = cs_q + 16'd1;
				q_desc.tail = spiee_pkg::TAIL_NONE;
			end else if (last_q == fin_q) begin
				// transfer complete
				if (cfg_q.auto_sleep) begin
					op_d        = spiee_pkg::OP_SLEEP;
					polls_d     = '0;
					q_desc.tail = spiee_pkg::TAIL_POLL;
					phase_d     = spiee_pkg::PH_STATUS;
				end else begin
					q_desc.tail = spiee_pkg::TAIL_DONE;
					phase_d     = spiee_pkg::PH_IDLE;
				end
			end else begin
				// page boundary: next chunk, poll again
				cs_d        = nxt_cs;
				last_d      = spiee_pkg::chunk_end(nxt_cs, fin_q, nxt_dist,
					cfg_q.page_size_log2, cfg_q.page_split);
				polls_d     = '0;
				q_desc.tail = spiee_pkg::TAIL_POLL;
				phase_d     = spiee_pkg::PH_STATUS;
			end
		end else begin
			q_desc.tail = spiee_pkg::TAIL_REJECT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= spiee_pkg::PH_IDLE;
			op_q    <= '0;
			cs_q    <= '0;
			fin_q   <= '0;
			last_q  <= '0;
			polls_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			op_q    <= op_d;
			cs_q    <= cs_d;
			fin_q   <= fin_d;
			last_q  <= last_d;
			polls_q <= polls_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.page_size_log2 <= spiee_pkg::RST_PAGE_LOG2;
			cfg_q.retry_limit    <= spiee_pkg::RST_RETRY;
			cfg_q.auto_sleep     <= spiee_pkg::RST_AUTOSLEEP;
			cfg_q.page_split     <= spiee_pkg::RST_SPLIT;
		end else if (cfg_valid) begin
			unique case (cfg_wr.index)
				spiee_pkg::CFG_PAGE_LOG2: cfg_q.page_size_log2 <= cfg_wr.data[3:0];
				spiee_pkg::CFG_RETRY:     cfg_q.retry_limit    <= cfg_wr.data;
				spiee_pkg::CFG_AUTOSLEEP: cfg_q.auto_sleep     <= cfg_wr.data[0];
				spiee_pkg::CFG_SPLIT:     cfg_q.page_split     <= cfg_wr.data[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/spiee_queue.sv
// Short descriptor queue between front and back.
// Depends on spiee_pkg for the descriptor type.
`default_nettype none

module spiee_queue #(
	parameter int DEPTH = spiee_pkg::Q_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  spiee_pkg::desc_t   wdata,
	output logic               full,
	input  wire logic          rd,
	output logic               empty,
	output spiee_pkg::desc_t   rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	spiee_pkg::desc_t  slot_q [DEPTH];
	logic [PTR_W-1:0]  wptr_q, rptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == CNT_FULL);
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PTR_W'(1);
			end
			if (rd) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PTR_W'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> design/spiee_back.sv
// Back end (uses spiee_pkg): expands each descriptor into result beats,
// one per cycle unless stalled by pop, into a single output register.
`default_nettype none

module spiee_back #(
	parameter int ADDR_WIDTH = spiee_pkg::ADDR_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  spiee_pkg::desc_t   q_desc,
	output logic               q_pop,
	input  wire logic          pop,
	output logic               empty,
	output spiee_pkg::res_t    result
);

	localparam int NBYTES    = (ADDR_WIDTH + 7) / 8;
	localparam int MAX_BEATS = 1 + ((NBYTES > 3) ? NBYTES : 3);
	localparam int IDX_W     = $clog2(MAX_BEATS);
	localparam logic [IDX_W-1:0] TOP_ABYTE = IDX_W'(NBYTES - 1);

	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] tpos;
	logic [IDX_W-1:0] abyte;
	logic [IDX_W:0]   tail_len;
	logic [IDX_W:0]   beat_cnt;
	logic             last_beat;
	logic             load;
	logic             emit;
	logic             valid_q;
	spiee_pkg::res_t  beat;
	spiee_pkg::res_t  res_q;

	assign load  = !valid_q || pop;
	assign emit  = !q_empty && load;
	assign tpos  = idx_q - IDX_W'(q_desc.head.en);
	assign abyte = TOP_ABYTE - tpos;

	always_comb begin
		unique case (q_desc.tail)
			spiee_pkg::TAIL_NONE: tail_len = '0;
			spiee_pkg::TAIL_POLL: tail_len = (IDX_W+1)'(3);
			spiee_pkg::TAIL_ADDR: tail_len = (IDX_W+1)'(NBYTES);
			default:              tail_len = (IDX_W+1)'(1);
		endcase
	end

	assign beat_cnt  = tail_len + (IDX_W+1)'(q_desc.head.en);
	assign last_beat = ({1'b0, idx_q} == beat_cnt - (IDX_W+1)'(1));

	always_comb begin
		beat = '0;
		if (q_desc.head.en && idx_q == '0) begin
			beat.out_byte    = q_desc.head.data;
			beat.frame_start = q_desc.head.fs;
			beat.frame_end   = q_desc.head.fe;
			beat.capture     = q_desc.head.cap;
		end else begin
			unique case (q_desc.tail)
				spiee_pkg::TAIL_DONE:    beat.outcome = spiee_pkg::OUT_DONE;
				spiee_pkg::TAIL_TIMEOUT: beat.outcome = spiee_pkg::OUT_TIMEOUT;
				spiee_pkg::TAIL_REJECT:  beat.outcome = spiee_pkg::OUT_REJECT;
				spiee_pkg::TAIL_WAIT:    beat.start_wait = 1'b1;
				spiee_pkg::TAIL_POLL: begin
					// WREN frame, then RDSR with one dummy byte
					unique case (tpos)
						IDX_W'(0): begin
							beat.out_byte    = spiee_pkg::CMD_WREN;
							beat.frame_start = 1'b1;
							beat.frame_end   = 1'b1;
						end
						IDX_W'(1): begin
							beat.out_byte    = spiee_pkg::CMD_RDSR;
							beat.frame_start = 1'b1;
						end
						default: begin
							beat.frame_end = 1'b1;
							beat.capture   = 1'b1;
						end
					endcase
				end
				spiee_pkg::TAIL_ADDR: begin
					// most significant byte first; bytes above bit 15 are zero
					if (abyte == IDX_W'(1)) begin
						beat.out_byte = q_desc.addr[15:8];
					end else if (abyte == '0) begin
						beat.out_byte = q_desc.addr[7:0];
					end
				end
				default: ;
			endcase
		end
		beat.last = last_beat;
	end

	assign q_pop = emit && last_beat;

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= emit;
			end
			if (emit) begin
				idx_q <= last_beat ? '0 : idx_q + IDX_W'(1);
			end
		end
	end

	assign empty  = !valid_q;
	assign result = res_q;

endmodule

`default_nettype wire

>>> design/spi_eeprom_command_sequencer.sv
// SPI EEPROM command sequencer for 25-series parts: turns write, read, chip erase,
// sleep and wake requests into byte beats for an external SPI shifter, with a
// WREN/RDSR ready poll before each command except wake, retries on tick, page
// splitting of writes and optional automatic wake/sleep around each write, read
// and erase. Each accepted item yields one to 1 + max(3, ceil(ADDR_WIDTH/8))
// result beats (an address frame is 1 + ceil(ADDR_WIDTH/8) beats). The front end
// takes one item per cycle while its descriptor queue (Q_DEPTH entries) has room;
// the back end emits one beat per cycle into the output register unless a held
// beat awaits pop. An accepted item goes to the queue, then its first beat to the
// output register. Configuration writes are always accepted (cfg_ready is tied
// high) and must only be issued while the block is idle. Uses spiee_pkg.
`default_nettype none

module spi_eeprom_command_sequencer #(
	parameter int ADDR_WIDTH = spiee_pkg::ADDR_WIDTH_DEF,
	parameter int Q_DEPTH    = spiee_pkg::Q_DEPTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// item side
	input  wire logic                              push,
	output logic                                   full,
	input  spiee_pkg::item_t                       item,
	// result side
	output logic                                   empty,
	input  wire logic                              pop,
	output spiee_pkg::res_t                        result,
	// register writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [spiee_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [spiee_pkg::CFG_DATA_W-1:0]  cfg_data
);

	spiee_pkg::cfg_wr_t cfg_wr;
	spiee_pkg::desc_t   wr_desc;
	spiee_pkg::desc_t   rd_desc;
	logic               q_wr;
	logic               q_full;
	logic               q_empty;
	logic               q_pop;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;
	assign full         = q_full;

	// Front: command state, config registers, one descriptor per item
	spiee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.q_full    (q_full),
		.cfg_valid (cfg_valid),
		.cfg_wr    (cfg_wr),
		.q_wr      (q_wr),
		.q_desc    (wr_desc)
	);

	// Decoupling queue, so a stalled result side stalls classification only once full
	spiee_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (wr_desc),
		.full   (q_full),
		.rd     (q_pop),
		.empty  (q_empty),
		.rdata  (rd_desc)
	);

	// Back: descriptor to beats
	spiee_back #(
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_desc  (rd_desc),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	// Status-only beats carry no bus byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.outcome != spiee_pkg::OUT_RUN || result.start_wait))
		|-> (result.out_byte == 8'h00 && !result.frame_start && !result.frame_end
			&& !result.capture))
		else $error("status beat carries bus fields");

	// A completion, timeout, reject or wait request always closes its item
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.outcome != spiee_pkg::OUT_RUN || result.start_wait))
		|-> result.last)
		else $error("status beat not marked last");

	// A descriptor leaves the queue only when the back end has one to expand
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("descriptor popped from empty queue");

endmodule

`default_nettype wire
